/* rtl/aacf_pkg.sv */
// aacf_pkg: shared types and constants of the aac access-unit packetizer
// used by the channel interfaces and by every module of the block
// no dependencies
package aacf_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int SIZE_W   = 13;
  localparam int CNT_W    = 12;

  // au header section: 0x00, 0x10, then 13-bit size and 3-bit index of zero
  localparam int AU_HDR_BYTES = 4;
  localparam int HDR_IDX_W    = $clog2(AU_HDR_BYTES);
  localparam logic [BYTE_W-1:0] HDR_LEN_HI = 8'h00;
  localparam logic [BYTE_W-1:0] HDR_LEN_LO = 8'h10;
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_HI  = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_LEN_LO  = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_SIZE_HI = HDR_IDX_W'(2);
  localparam logic [HDR_IDX_W-1:0] HDR_IDX_SIZE_LO = HDR_IDX_W'(AU_HDR_BYTES - 1);

  // packet size limit, header included
  localparam logic [CNT_W-1:0] MAX_PKT_RESET = CNT_W'(1500);
  localparam logic [CNT_W-1:0] PAYLOAD_LIMIT_RESET = CNT_W'(1500 - AU_HDR_BYTES);

  // one input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [SIZE_W-1:0] au_size;
    logic              last_of_au;
  } item_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_packet;
    logic              marker;
    logic              last;
  } result_t;

  // held input item as seen by the framer
  typedef struct packed {
    logic  valid;
    item_t item;
  } held_t;

  // result offered to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } emit_t;

endpackage

/* rtl/aacf_ifs.sv */
// aacf channel interfaces: input bytes, packet bytes and the limit register write
// depends on aacf_pkg for field widths

interface aacf_in_if;
  logic                          valid;
  logic                          ready;
  logic [aacf_pkg::BYTE_W-1:0]   data_byte;
  logic [aacf_pkg::SIZE_W-1:0]   au_size;
  logic                          last_of_au;

  modport source (output valid, output data_byte, output au_size, output last_of_au,
                  input ready);
  modport sink   (input valid, input data_byte, input au_size, input last_of_au,
                  output ready);
endinterface

interface aacf_out_if;
  logic                          valid;
  logic                          ready;
  logic [aacf_pkg::BYTE_W-1:0]   out_byte;
  logic                          end_of_packet;
  logic                          marker;
  logic                          last;

  modport source (output valid, output out_byte, output end_of_packet, output marker,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input end_of_packet, input marker,
                  input last, output ready);
endinterface

interface aacf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [aacf_pkg::CNT_W-1:0]    max_packet_bytes;

  modport source (output valid, output max_packet_bytes, input ready);
  modport sink   (input valid, input max_packet_bytes, output ready);
endinterface

/* rtl/aacf_in_stage.sv */
// aacf_in_stage: input register holding one access-unit byte until the framer consumes it
// depends on aacf_pkg
module aacf_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aacf_pkg::item_t      in_item,
  input  logic                 pop,
  output aacf_pkg::held_t      held
);
  import aacf_pkg::*;

  logic  full;
  item_t item;

  // free slot, or the held byte leaves this cycle
  assign in_ready = !full || pop;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign held.valid = full;
  assign held.item  = item;

endmodule

/* rtl/aacf_framer.sv */
// aacf_framer: packet state, header sequencing and end-of-packet decision
// depends on aacf_pkg; feeds aacf_out_stage, drains aacf_in_stage
module aacf_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [aacf_pkg::CNT_W-1:0]   cfg_max_packet_bytes,
  input  aacf_pkg::held_t              held,
  input  logic                         can_load,
  output logic                         pop,
  output aacf_pkg::emit_t              emit
);
  import aacf_pkg::*;

  logic                 in_packet;
  logic [CNT_W-1:0]     payload_count;
  logic [CNT_W-1:0]     payload_count_next;
  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [CNT_W-1:0]     payload_limit;
  logic                 fire;
  logic                 eop;
  logic [BYTE_W-1:0]    hdr_byte;

  // payload limit, kept ready-subtracted; saturates at one byte
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= PAYLOAD_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_max_packet_bytes > CNT_W'(AU_HDR_BYTES)) begin
        payload_limit <= cfg_max_packet_bytes - CNT_W'(AU_HDR_BYTES);
      end else begin
        payload_limit <= CNT_W'(1);
      end
    end
  end

  // one result per cycle whenever a byte is held and the output register has room
  assign fire = held.valid && can_load;
  assign pop  = fire && in_packet;

  assign payload_count_next = payload_count + CNT_W'(1);
  assign eop = held.item.last_of_au || (payload_count_next >= payload_limit);

  // au header section bytes
  always_comb begin
    unique case (hdr_idx)
      HDR_IDX_LEN_HI:  hdr_byte = HDR_LEN_HI;
      HDR_IDX_LEN_LO:  hdr_byte = HDR_LEN_LO;
      HDR_IDX_SIZE_HI: hdr_byte = held.item.au_size[SIZE_W-1:SIZE_W-BYTE_W];
      HDR_IDX_SIZE_LO: hdr_byte = {held.item.au_size[SIZE_W-BYTE_W-1:0],
                                   (2*BYTE_W-SIZE_W)'(0)};
      default:         hdr_byte = HDR_LEN_HI;
    endcase
  end

  // result selection
  always_comb begin
    emit.valid = fire;
    if (in_packet) begin
      emit.res.out_byte      = held.item.data_byte;
      emit.res.end_of_packet = eop;
      emit.res.marker        = held.item.last_of_au;
      emit.res.last          = 1'b1;
    end else begin
      emit.res.out_byte      = hdr_byte;
      emit.res.end_of_packet = 1'b0;
      emit.res.marker        = 1'b0;
      emit.res.last          = 1'b0;
    end
  end

  // packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet     <= 1'b0;
      payload_count <= '0;
      hdr_idx       <= '0;
    end else if (fire) begin
      if (in_packet) begin
        in_packet     <= !eop;
        payload_count <= eop ? '0 : payload_count_next;
      end else if (hdr_idx == HDR_IDX_SIZE_LO) begin
        in_packet     <= 1'b1;
        payload_count <= '0;
        hdr_idx       <= '0;
      end else begin
        hdr_idx       <= hdr_idx + HDR_IDX_W'(1);
      end
    end
  end

  // header counter only runs while no packet is open
  a_hdr_closed: assert property (@(posedge clk) disable iff (rst)
    hdr_idx != '0 |-> !in_packet)
    else $error("header sequence running inside an open packet");

  // a byte is only released once its packet is open
  a_pop_open: assert property (@(posedge clk) disable iff (rst)
    fire && !in_packet |-> !pop)
    else $error("byte released during header bytes");

  // end of unit always closes the packet
  a_au_close: assert property (@(posedge clk) disable iff (rst)
    fire && in_packet && held.item.last_of_au |=> !in_packet && payload_count == '0)
    else $error("packet left open after last byte of unit");

  // opening a packet follows the final header byte
  a_open: assert property (@(posedge clk) disable iff (rst)
    fire && !in_packet && hdr_idx == HDR_IDX_SIZE_LO |=> in_packet && hdr_idx == '0)
    else $error("packet not opened after header section");

endmodule

/* rtl/aacf_out_stage.sv */
// aacf_out_stage: result register between the framer and the output channel
// depends on aacf_pkg
module aacf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  aacf_pkg::emit_t    emit,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output aacf_pkg::result_t  out_res
);
  import aacf_pkg::*;

  logic    full;
  result_t res;

  // room when empty or the current transaction completes
  assign can_load = !full || out_ready;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (can_load) begin
      full <= emit.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_load && emit.valid) begin
      res <= emit.res;
    end
  end

  assign out_valid = full;
  assign out_res   = res;

endmodule

/* rtl/aac_au_rtp_fragmenter_core.sv */
// aac_au_rtp_fragmenter_core: top level of the aac access-unit packetizer
// depends on aacf_pkg, aacf_ifs, aacf_in_stage, aacf_framer, aacf_out_stage
//
//  channel   dir  payload                                       transaction
//  in_ch     in   data_byte, au_size, last_of_au                one unit byte
//  out_ch    out  out_byte, end_of_packet, marker, last         one packet byte
//  cfg_ch    in   max_packet_bytes                              limit write
//
// a byte inside an open packet gives one result; a byte that opens a packet gives
// the four header bytes, then itself, all through the single result register
// reset clears the packet state and loads a limit of 1500 bytes; no clearing pass
// while a result waits on a stalled output the input register takes one more byte
// if it is empty, then holds in_ch.ready low until the output moves again
// cfg_ch is always ready and its write takes effect on the next byte
module aac_au_rtp_fragmenter_core (
  input  logic         clk,
  input  logic         rst,
  aacf_in_if.sink      in_ch,
  aacf_out_if.source   out_ch,
  aacf_cfg_if.sink     cfg_ch
);
  import aacf_pkg::*;

  item_t   in_item;
  held_t   held;
  emit_t   emit;
  result_t out_res;
  logic    pop;
  logic    can_load;

  assign cfg_ch.ready = 1'b1;

  // input payload gathered into one item
  assign in_item.data_byte  = in_ch.data_byte;
  assign in_item.au_size    = in_ch.au_size;
  assign in_item.last_of_au = in_ch.last_of_au;

  aacf_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .pop      (pop),
    .held     (held)
  );

  aacf_framer u_framer (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_ch.valid),
    .cfg_max_packet_bytes (cfg_ch.max_packet_bytes),
    .held                 (held),
    .can_load             (can_load),
    .pop                  (pop),
    .emit                 (emit)
  );

  aacf_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  // result fields onto the output channel
  assign out_ch.out_byte      = out_res.out_byte;
  assign out_ch.end_of_packet = out_res.end_of_packet;
  assign out_ch.marker        = out_res.marker;
  assign out_ch.last          = out_res.last;

endmodule

/* dv/aacf_packet_checker.sv */
// aacf_packet_checker: watches the byte, packet and limit channels of the packetizer,
// predicts every packet byte and compares it with what the block puts out
// depends on aacf_pkg for the item and result types
`timescale 1ns / 100ps

module aacf_packet_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  aacf_pkg::item_t            in_item,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  aacf_pkg::result_t          out_res,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [aacf_pkg::CNT_W-1:0] cfg_limit,
  output int                         fail_count,
  output int                         pending
);
  import aacf_pkg::*;

  // own copy of the limit register and the packet state
  logic [CNT_W-1:0] limit_reg;
  logic             pkt_open;
  logic [CNT_W-1:0] fill_count;
  result_t          expected_bytes[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic result_t make_result(logic [BYTE_W-1:0] b, logic eop, logic mark,
                                          logic lst);
    result_t r;
    r.out_byte      = b;
    r.end_of_packet = eop;
    r.marker        = mark;
    r.last          = lst;
    return r;
  endfunction

  // expected packet bytes caused by one unit byte
  task automatic frame_byte(input item_t it);
    logic [CNT_W-1:0] pay_limit;
    logic             closes;
    // limits at or below the header size still let one payload byte through
    pay_limit = (limit_reg > CNT_W'(AU_HDR_BYTES)) ? limit_reg - CNT_W'(AU_HDR_BYTES)
                                                   : CNT_W'(1);
    if (!pkt_open) begin
      expected_bytes.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b0));
      expected_bytes.push_back(make_result(8'h10, 1'b0, 1'b0, 1'b0));
      expected_bytes.push_back(make_result(it.au_size[12:5], 1'b0, 1'b0, 1'b0));
      expected_bytes.push_back(make_result({it.au_size[4:0], 3'b000}, 1'b0, 1'b0, 1'b0));
      pkt_open   = 1'b1;
      fill_count = '0;
    end
    fill_count = fill_count + CNT_W'(1);
    closes     = it.last_of_au || (fill_count >= pay_limit);
    expected_bytes.push_back(make_result(it.data_byte, closes, it.last_of_au, 1'b1));
    if (closes) begin
      pkt_open   = 1'b0;
      fill_count = '0;
    end
  endtask

  // compare accepted packet bytes, then predict from accepted unit bytes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      limit_reg  = MAX_PKT_RESET;
      pkt_open   = 1'b0;
      fill_count = '0;
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected packet byte %0h with nothing outstanding", out_res.out_byte);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (out_res != want) begin
            fail_count <= fail_count + 1;
            if (out_res.out_byte != want.out_byte)
              $error("out_byte: expected %0h, actual %0h", want.out_byte, out_res.out_byte);
            if (out_res.end_of_packet != want.end_of_packet)
              $error("end_of_packet: expected %0b, actual %0b", want.end_of_packet,
                     out_res.end_of_packet);
            if (out_res.marker != want.marker)
              $error("marker: expected %0b, actual %0b", want.marker, out_res.marker);
            if (out_res.last != want.last)
              $error("last: expected %0b, actual %0b", want.last, out_res.last);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        limit_reg = cfg_limit;
      if (in_valid && in_ready)
        frame_byte(in_item);
    end
    pending <= expected_bytes.size();
  end

endmodule

/* dv/tb_aac_au_rtp_fragmenter_core.sv */
// tb_aac_au_rtp_fragmenter_core: drives access units and limit writes into the packetizer
// with random gaps and stalls, and gives the verdict from the packet checker
// depends on aacf_pkg, aacf_ifs, aac_au_rtp_fragmenter_core and aacf_packet_checker
`timescale 1ns / 100ps

module tb_aac_au_rtp_fragmenter_core;
  import aacf_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 38;
  localparam int NUM_PHASES   = 8;

  logic clk;
  logic rst;
  logic hold_req;
  logic no_idle;
  int   fails;
  int   pending;
  int   quiet_cycles;

  aacf_in_if  in_ch ();
  aacf_out_if out_ch ();
  aacf_cfg_if cfg_ch ();

  aac_au_rtp_fragmenter_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  aacf_packet_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    ({in_ch.data_byte, in_ch.au_size, in_ch.last_of_au}),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    ({out_ch.out_byte, out_ch.end_of_packet, out_ch.marker, out_ch.last}),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_limit  (cfg_ch.max_packet_bytes),
    .fail_count (fails),
    .pending    (pending)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no transaction on any channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("aac_au_rtp_fragmenter_core test failed");
      $finish;
    end
  end

  // receiver: random ready stretches, plus one long hold-off on request
  initial begin : receiver
    int r;
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ch.ready = 1'b1;
          n = $urandom_range(1, 20);
        end else if (r < 90) begin
          out_ch.ready = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ch.ready = 1'b0;
          n = $urandom_range(10, 50);
        end
        repeat (n) @(negedge clk);
      end
    end
  end

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one unit byte; called and returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [SIZE_W-1:0] size,
                           input logic lst);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_byte  = b;
    in_ch.au_size    = size;
    in_ch.last_of_au = lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // a unit of random bytes; open leaves its packet unfinished, noisy scatters end flags
  task automatic send_unit(input int len, input logic [SIZE_W-1:0] size, input logic open,
                           input logic noisy);
    logic lst;
    for (int i = 0; i < len; i++) begin
      if (noisy)
        lst = ($urandom_range(0, 3) == 0);
      else
        lst = (i == len - 1) && !open;
      send_byte(8'($urandom_range(0, 255)), size, lst);
    end
  endtask

  // limit write once every expected byte is out
  task automatic set_limit(input logic [CNT_W-1:0] v);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_ch.valid            = 1'b1;
    cfg_ch.max_packet_bytes = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // stimulus
  initial begin : stimulus
    int count;
    int len;
    int r;
    logic [SIZE_W-1:0] size;
    logic open;
    logic noisy;
    rst                     = 1'b1;
    hold_req                = 1'b0;
    no_idle                 = 1'b0;
    in_ch.valid             = 1'b0;
    in_ch.data_byte         = '0;
    in_ch.au_size           = '0;
    in_ch.last_of_au        = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.max_packet_bytes = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: size and byte extremes at the reset limit
    send_byte(8'h00, 13'd1, 1'b1);
    send_byte(8'hff, 13'h1fff, 1'b0);
    send_byte(8'ha5, 13'h1fff, 1'b1);
    send_byte(8'h5a, 13'd0, 1'b1);
    send_byte(8'h3c, 13'h1555, 1'b1);
    send_byte(8'hc3, 13'h0aaa, 1'b1);
    // smallest legal limit: one payload byte per packet
    set_limit(12'd5);
    send_unit(3, 13'd3, 1'b0, 1'b0);
    // limits below the header size saturate to one payload byte
    set_limit(12'd0);
    send_unit(2, 13'd2, 1'b0, 1'b0);
    set_limit(12'd4);
    send_unit(2, 13'd2, 1'b0, 1'b0);
    // packet closed on the limit and then on the unit end
    set_limit(12'd7);
    send_unit(4, 13'd4, 1'b0, 1'b0);
    // limit lowered while a packet is open
    set_limit(12'd1500);
    send_unit(4, 13'd6, 1'b1, 1'b0);
    set_limit(12'd6);
    send_unit(2, 13'd6, 1'b0, 1'b0);
    // largest limit
    set_limit(12'd4095);
    send_unit(2, 13'd2, 1'b0, 1'b0);

    // random phases, each under its own limit
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_limit(12'd1500);
        1:       set_limit(12'd5);
        2:       set_limit(12'($urandom_range(6, 24)));
        3:       set_limit(12'($urandom_range(0, 4)));
        4:       set_limit(12'd4095);
        5:       set_limit(12'($urandom_range(5, 4095)));
        6:       set_limit(12'd9);
        default: set_limit(12'($urandom_range(6, 40)));
      endcase
      no_idle = (ph == 4);
      if (ph == 0) hold_req = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 90)
          len = $urandom_range(1, 12);
        else
          len = $urandom_range(30, 80);
        noisy = ($urandom_range(0, 99) < 5);
        if ($urandom_range(0, 99) < 85)
          size = SIZE_W'(len);
        else
          size = SIZE_W'($urandom_range(0, 8191));
        open = (count + len >= PHASE_ITEMS) && ($urandom_range(0, 2) == 0);
        send_unit(len, size, open, noisy);
        count += len;
      end
    end
    no_idle     = 1'b0;
    in_ch.valid = 1'b0;

    // drain, then let any stray byte show up
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0)
      $display("aac_au_rtp_fragmenter_core test passed");
    else
      $display("aac_au_rtp_fragmenter_core test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/aacf_pkg.sv
rtl/aacf_ifs.sv
rtl/aacf_in_stage.sv
rtl/aacf_framer.sv
rtl/aacf_out_stage.sv
rtl/aac_au_rtp_fragmenter_core.sv
dv/aacf_packet_checker.sv
dv/tb_aac_au_rtp_fragmenter_core.sv
